// ----- rtl/sld_pkg.sv -----
// Shared types, sizes and the segment position table of the segment LCD fade driver.
// Used by sld_ctrl, sld_datapath and segment_lcd_fade_driver; depends on nothing else.

package sld_pkg;

  localparam int SEGMENT_COUNT = 109;
  localparam int DISPLAY_BYTES = 24;
  localparam int TABLE_LEN     = 109;

  localparam int PAIR_COUNT = (SEGMENT_COUNT + 1) / 2;
  localparam int PAIR_W     = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;
  localparam int SEG_W      = PAIR_W + 1;
  localparam int DB_W       = $clog2(DISPLAY_BYTES);

  localparam logic [2:0] MODE_ON_A = 3'd5;
  localparam logic [2:0] MODE_ON_B = 3'd6;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_MODE     = 2'd0,
    CFG_CONTRAST = 2'd1,
    CFG_RESID_EN = 2'd2,
    CFG_SCALE    = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_TGT_MUL,
    ST_TGT_RCP,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              bus_write;
    logic              bus_read;
    logic              rd_load;
    logic              tgt_mul;
    logic              tgt_rcp;
    logic              pair_issue;
    logic              pair_last;
    logic [PAIR_W-1:0] pair_idx;
  } cmd_t;

  // byte position in bits [7:3], bit position in bits [2:0]
  localparam logic [7:0] SEG_MAP [TABLE_LEN] = '{
    {5'h11,3'd6}, {5'h11,3'd2}, {5'h12,3'd6}, {5'h12,3'd2}, {5'h13,3'd6}, {5'h13,3'd2},
    {5'h14,3'd6}, {5'h14,3'd2}, {5'h15,3'd6}, {5'h15,3'd2}, {5'h16,3'd4}, {5'h16,3'd2},
    {5'h16,3'd0}, {5'h08,3'd1}, {5'h01,3'd5}, {5'h01,3'd6}, {5'h01,3'd4}, {5'h09,3'd5},
    {5'h09,3'd6}, {5'h09,3'd4}, {5'h11,3'd5}, {5'h11,3'd4}, {5'h01,3'd1}, {5'h01,3'd2},
    {5'h01,3'd0}, {5'h09,3'd1}, {5'h09,3'd2}, {5'h09,3'd0}, {5'h11,3'd1}, {5'h11,3'd0},
    {5'h02,3'd5}, {5'h02,3'd6}, {5'h02,3'd4}, {5'h0A,3'd5}, {5'h0A,3'd6}, {5'h0A,3'd4},
    {5'h12,3'd5}, {5'h12,3'd4}, {5'h02,3'd1}, {5'h02,3'd2}, {5'h02,3'd0}, {5'h0A,3'd1},
    {5'h0A,3'd2}, {5'h0A,3'd0}, {5'h12,3'd1}, {5'h12,3'd0}, {5'h03,3'd5}, {5'h03,3'd6},
    {5'h03,3'd4}, {5'h0B,3'd5}, {5'h0B,3'd6}, {5'h0B,3'd4}, {5'h13,3'd5}, {5'h13,3'd4},
    {5'h03,3'd1}, {5'h03,3'd2}, {5'h03,3'd0}, {5'h0B,3'd1}, {5'h0B,3'd2}, {5'h0B,3'd0},
    {5'h13,3'd1}, {5'h13,3'd0}, {5'h04,3'd5}, {5'h04,3'd6}, {5'h04,3'd4}, {5'h0C,3'd5},
    {5'h0C,3'd6}, {5'h0C,3'd4}, {5'h14,3'd5}, {5'h14,3'd4}, {5'h04,3'd1}, {5'h04,3'd2},
    {5'h04,3'd0}, {5'h0C,3'd1}, {5'h0C,3'd2}, {5'h0C,3'd0}, {5'h14,3'd1}, {5'h14,3'd0},
    {5'h05,3'd5}, {5'h05,3'd6}, {5'h05,3'd4}, {5'h0D,3'd5}, {5'h0D,3'd6}, {5'h0D,3'd4},
    {5'h15,3'd5}, {5'h15,3'd4}, {5'h05,3'd1}, {5'h05,3'd2}, {5'h05,3'd0}, {5'h0D,3'd1},
    {5'h0D,3'd2}, {5'h0D,3'd0}, {5'h15,3'd1}, {5'h15,3'd0}, {5'h16,3'd6}, {5'h06,3'd5},
    {5'h06,3'd6}, {5'h06,3'd4}, {5'h0E,3'd5}, {5'h0E,3'd6}, {5'h0E,3'd4}, {5'h16,3'd5},
    {5'h06,3'd1}, {5'h06,3'd2}, {5'h06,3'd0}, {5'h0E,3'd1}, {5'h0E,3'd2}, {5'h0E,3'd0},
    {5'h16,3'd1}
  };

  function automatic logic [7:0] seg_pos(input logic [7:0] idx);
    logic [7:0] pos;
    pos = 8'd0;
    if (idx < 8'(TABLE_LEN)) begin
      pos = SEG_MAP[idx[6:0]];
    end
    return pos;
  endfunction

  // true when the segment has a table entry that lands inside the display
  function automatic logic seg_ok(input logic [7:0] idx);
    logic ok;
    ok = 1'b0;
    if (idx < 8'(TABLE_LEN)) begin
      ok = ({1'b0, SEG_MAP[idx[6:0]][7:3]} < 6'(DISPLAY_BYTES));
    end
    return ok;
  endfunction

endpackage

// ----- rtl/sld_ctrl.sv -----
// Controller state machine of the segment LCD fade driver: accepts items and
// sequences bus accesses, target setup and the pair walk. Depends on sld_pkg.

module sld_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_operation,
  output logic          busy,
  output sld_pkg::cmd_t cmd
);
  import sld_pkg::*;

  state_t            state_r, state_nxt;
  logic [PAIR_W-1:0] pair_r, pair_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pair_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pair_r  <= pair_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    pair_nxt       = pair_r;
    cmd            = '0;
    cmd.pair_idx   = pair_r;
    busy           = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        pair_nxt = '0;
        if (start) begin
          unique case (in_operation)
            OP_WRITE: cmd.bus_write = 1'b1;
            OP_READ: begin
              cmd.bus_read = 1'b1;
              state_nxt    = ST_READ;
            end
            OP_TICK: state_nxt = ST_TGT_MUL;
            default: ;  // drop the unused operation code
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_load = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_TGT_MUL: begin
        cmd.tgt_mul = 1'b1;
        state_nxt   = ST_TGT_RCP;
      end
      ST_TGT_RCP: begin
        cmd.tgt_rcp = 1'b1;
        state_nxt   = ST_WALK;
      end
      ST_WALK: begin
        cmd.pair_issue = 1'b1;
        cmd.pair_last  = (pair_r == PAIR_W'(PAIR_COUNT - 1));
        if (cmd.pair_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          pair_nxt = pair_r + 1'b1;
        end
      end
      ST_DRAIN: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/sld_datapath.sv -----
// Datapath of the segment LCD fade driver: configuration and bus registers,
// display and intensity memories, target arithmetic and result registers. Depends on sld_pkg.

module sld_datapath (
  input  logic          clk,
  input  logic          rst_n,
  input  sld_pkg::cmd_t cmd,
  input  logic [4:0]    in_address,
  input  logic [7:0]    in_write_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_data,
  output logic          out_strobe,
  output logic [7:0]    out_read_data,
  output logic [5:0]    out_pair_index,
  output logic [7:0]    out_alpha_first,
  output logic [7:0]    out_alpha_second,
  output logic          out_second_valid,
  output logic          out_last
);
  import sld_pkg::*;

  localparam logic [19:0] OFF_BASE   = 20'd51000;    // 510 * 100
  localparam logic [19:0] OFF_STEP   = 20'd22950;    // 510 * 45
  localparam logic [28:0] OFF_BIAS   = 29'd2560000;  // half of 5120000
  localparam int          PRE_SHIFT  = 13;           // 5120000 = 2^13 * 625
  localparam logic [32:0] RCP_MUL    = 33'd107375;   // ceil(2^26 / 625)
  localparam int          RCP_SHIFT  = 26;

  function automatic logic [7:0] on_level(input logic [4:0] c);
    logic [7:0] lvl;
    case (c)
      5'd0:    lvl = 8'd191;
      5'd1:    lvl = 8'd198;
      5'd2:    lvl = 8'd205;
      5'd3:    lvl = 8'd213;
      5'd4:    lvl = 8'd220;
      5'd5:    lvl = 8'd227;
      5'd6:    lvl = 8'd234;
      5'd7:    lvl = 8'd241;
      5'd8:    lvl = 8'd248;
      default: lvl = 8'd255;
    endcase
    return lvl;
  endfunction

  function automatic logic [7:0] fade(input logic [7:0] old, input logic lit,
                                      input logic en, input logic resid,
                                      input logic [7:0] on_t, input logic [7:0] off_t);
    logic [7:0] tgt;
    logic [8:0] sum;
    tgt = en ? (lit ? on_t : off_t) : 8'd0;
    sum = {1'b0, old} + {1'b0, tgt} + 9'd1;
    return resid ? sum[8:1] : tgt;
  endfunction

  // configuration
  logic [2:0] mode_r;
  logic [4:0] contrast_r;
  logic       resid_r;
  logic [8:0] scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 3'd0;
      contrast_r <= 5'd0;
      resid_r    <= 1'b0;
      scale_r    <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_MODE:     mode_r     <= cfg_data[2:0];
        CFG_CONTRAST: contrast_r <= cfg_data[4:0];
        CFG_RESID_EN: resid_r    <= cfg_data[0];
        CFG_SCALE:    scale_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // targets: multiplies split over the tgt_mul and tgt_rcp steps, registered between
  logic [28:0] tprod_r;
  logic [32:0] off_q;
  logic [7:0]  on_tgt_r, off_tgt_r;

  assign off_q = 33'(tprod_r[28:PRE_SHIFT]) * RCP_MUL;

  always_ff @(posedge clk) begin
    if (cmd.tgt_mul) begin
      tprod_r  <= 29'(OFF_BASE + 20'(contrast_r) * OFF_STEP) * 29'(scale_r) + OFF_BIAS;
      on_tgt_r <= on_level(contrast_r);
    end
    // quotient stays below 77 over the whole register range, so no saturation
    if (cmd.tgt_rcp) begin
      off_tgt_r <= 8'(off_q >> RCP_SHIFT);
    end
  end

  // bus side
  logic             bus_hit;
  logic             disp_we;
  logic [7:0]       control_r;
  logic [DISPLAY_BYTES-1:0] disp_vld_r;

  assign bus_hit = (in_address != 5'd0) && ({1'b0, in_address} < 6'(DISPLAY_BYTES));
  assign disp_we = cmd.bus_write && bus_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r  <= 8'd0;
      disp_vld_r <= '0;
    end else if (cmd.bus_write) begin
      if (in_address == 5'd0) begin
        control_r <= in_write_data;
      end
      if (disp_we) begin
        disp_vld_r[in_address[DB_W-1:0]] <= 1'b1;
      end
    end
  end

  // display memory, two registered read ports
  logic [7:0]      disp_mem [DISPLAY_BYTES];
  logic [7:0]      pos_a, pos_b;
  logic [SEG_W-1:0] seg_a, seg_b;
  logic [DB_W-1:0] addr_a, addr_b;
  logic [7:0]      disp_a_r, disp_b_r;

  assign seg_a  = {cmd.pair_idx, 1'b0};
  assign seg_b  = {cmd.pair_idx, 1'b1};
  assign pos_a  = seg_pos(8'(seg_a));
  assign pos_b  = seg_pos(8'(seg_b));
  assign addr_a = cmd.bus_read ? in_address[DB_W-1:0] : pos_a[DB_W+2:3];
  assign addr_b = pos_b[DB_W+2:3];

  always_ff @(posedge clk) begin
    if (disp_we) begin
      disp_mem[in_address[DB_W-1:0]] <= in_write_data;
    end
    if (cmd.bus_read || cmd.pair_issue) begin
      disp_a_r <= disp_mem[addr_a];
    end
    if (cmd.pair_issue) begin
      disp_b_r <= disp_mem[addr_b];
    end
  end

  // intensity memory, one row per pair
  logic [15:0]           alpha_mem [PAIR_COUNT];
  logic [PAIR_COUNT-1:0] alpha_vld_r;
  logic [15:0]           alpha_rd_r;

  // walk stage registers
  logic              s1_v_r;
  logic              s1_last_r;
  logic [PAIR_W-1:0] s1_pair_r;
  logic              s1_ok_a_r, s1_ok_b_r;
  logic [2:0]        s1_bit_a_r, s1_bit_b_r;
  logic              s1_secv_r;
  logic              s1_avld_r;
  logic              rd_hit_r, rd_ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.pair_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pair_issue) begin
      s1_last_r  <= cmd.pair_last;
      s1_pair_r  <= cmd.pair_idx;
      s1_ok_a_r  <= seg_ok(8'(seg_a)) && disp_vld_r[addr_a];
      s1_ok_b_r  <= seg_ok(8'(seg_b)) && disp_vld_r[addr_b];
      s1_bit_a_r <= pos_a[2:0];
      s1_bit_b_r <= pos_b[2:0];
      s1_secv_r  <= (8'(seg_b) < 8'(SEGMENT_COUNT));
      s1_avld_r  <= alpha_vld_r[cmd.pair_idx];
      alpha_rd_r <= alpha_mem[cmd.pair_idx];
    end
    if (cmd.bus_read) begin
      rd_hit_r  <= bus_hit && disp_vld_r[addr_a];
      rd_ctrl_r <= (in_address == 5'd0);
    end
  end

  // fade the pair and write it back
  logic       en;
  logic [7:0] on_eff, off_eff;
  logic [7:0] old_a, old_b, new_a, new_b;
  logic       lit_a, lit_b;

  assign en      = (mode_r == MODE_ON_A) || (mode_r == MODE_ON_B);
  assign on_eff  = resid_r ? on_tgt_r : 8'd255;
  assign off_eff = resid_r ? off_tgt_r : 8'd0;
  assign old_a   = s1_avld_r ? alpha_rd_r[7:0] : 8'd0;
  assign old_b   = s1_avld_r ? alpha_rd_r[15:8] : 8'd0;
  assign lit_a   = s1_ok_a_r && disp_a_r[s1_bit_a_r];
  assign lit_b   = s1_ok_b_r && disp_b_r[s1_bit_b_r];
  assign new_a   = fade(old_a, lit_a, en, resid_r, on_eff, off_eff);
  assign new_b   = fade(old_b, lit_b, en, resid_r, on_eff, off_eff);

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      alpha_mem[s1_pair_r] <= {new_b, new_a};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_vld_r <= '0;
    end else if (s1_v_r) begin
      alpha_vld_r[s1_pair_r] <= 1'b1;
    end
  end

  // result registers
  logic       strobe_r, strobe_nxt;
  logic [7:0] rdata_r, rdata_nxt;
  logic [5:0] pidx_r, pidx_nxt;
  logic [7:0] af_r, af_nxt, as_r, as_nxt;
  logic       sv_r, sv_nxt, last_r, last_nxt;

  always_comb begin
    strobe_nxt = 1'b0;
    rdata_nxt  = 8'd0;
    pidx_nxt   = 6'd0;
    af_nxt     = 8'd0;
    as_nxt     = 8'd0;
    sv_nxt     = 1'b0;
    last_nxt   = 1'b0;
    if (s1_v_r) begin
      strobe_nxt = 1'b1;
      pidx_nxt   = 6'(s1_pair_r);
      af_nxt     = new_a;
      as_nxt     = s1_secv_r ? new_b : 8'd0;
      sv_nxt     = s1_secv_r;
      last_nxt   = s1_last_r;
    end else if (cmd.rd_load) begin
      strobe_nxt = 1'b1;
      rdata_nxt  = rd_ctrl_r ? control_r : (rd_hit_r ? disp_a_r : 8'd0);
      last_nxt   = 1'b1;
    end else if (cmd.bus_write) begin
      strobe_nxt = 1'b1;
      last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rdata_nxt;
    pidx_r  <= pidx_nxt;
    af_r    <= af_nxt;
    as_r    <= as_nxt;
    sv_r    <= sv_nxt;
    last_r  <= last_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_read_data    = rdata_r;
  assign out_pair_index   = pidx_r;
  assign out_alpha_first  = af_r;
  assign out_alpha_second = as_r;
  assign out_second_valid = sv_r;
  assign out_last         = last_r;

endmodule

// ----- rtl/segment_lcd_fade_driver.sv -----
// Top level of the segment LCD fade driver: joins the controller and the datapath.
// Depends on sld_pkg, sld_ctrl and sld_datapath.

// Usage: raise start with an item while busy is low; the item is taken at that
// edge. Results come out of registers, one per cycle marked by out_strobe, and
// there is no way to hold them off, so capture every strobed cycle. A bus write
// leaves busy low, so the next item may follow at once, and gives its result
// in the next cycle. A bus read first reads the registered display memory, then
// loads the result in the read state. A frame tick takes the item, does the
// target arithmetic in the tgt_mul and tgt_rcp states (two multiplies, then
// one), walks all 55 rows of the intensity memory one pair row per cycle, then
// finishes the last pair in the drain state; busy stays high from the target
// arithmetic to the end. Its 55 results strobe on consecutive cycles, the last
// marked by out_last. Operation three is taken and does nothing. Valid bits
// stand in for reset of both memories, so no clearing pass is needed.
// Write configuration only while busy is low and no results are still due.

module segment_lcd_fade_driver (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_operation,
  input  logic [4:0] in_address,
  input  logic [7:0] in_write_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  output logic       out_strobe,
  output logic [7:0] out_read_data,
  output logic [5:0] out_pair_index,
  output logic [7:0] out_alpha_first,
  output logic [7:0] out_alpha_second,
  output logic       out_second_valid,
  output logic       out_last
);
  import sld_pkg::*;

  // commands from the sequencer into the datapath
  cmd_t cmd;

  sld_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .busy         (busy),
    .cmd          (cmd)
  );

  sld_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_strobe       (out_strobe),
    .out_read_data    (out_read_data),
    .out_pair_index   (out_pair_index),
    .out_alpha_first  (out_alpha_first),
    .out_alpha_second (out_alpha_second),
    .out_second_valid (out_second_valid),
    .out_last         (out_last)
  );

endmodule
